FILE: sv/rgbfb_pkg.sv
// Shared types, constants and pixel helpers for the RGB565 frame store blend engine.
`default_nettype none
package rgbfb_pkg;

   typedef enum logic [2:0] {
      CMD_PIXEL = 3'd0,
      CMD_BLEND = 3'd1,
      CMD_RECT  = 3'd2,
      CMD_READ  = 3'd3,
      CMD_TAKE  = 3'd4
   } cmd_type;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int RegWidth = 9;

   localparam logic RegActiveWidth  = 1'b0;
   localparam logic RegActiveHeight = 1'b1;

   localparam logic [RegWidth-1:0] ResetActiveWidth  = 9'd128;
   localparam logic [RegWidth-1:0] ResetActiveHeight = 9'd160;

   localparam logic [31:0] SpreadMask = 32'h07e0_f81f;
   localparam logic [7:0] Opaque = 8'hFF;

   function automatic logic [15:0] swap16(input logic [15:0] value);
      return {value[7:0], value[15:8]};
   endfunction

   function automatic logic [31:0] spread(input logic [15:0] value);
      return ({16'h0000, value} | {value, 16'h0000}) & SpreadMask;
   endfunction

endpackage
`default_nettype wire

FILE: sv/rgbfb_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module rgbfb_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [DATA_WIDTH-1:0]    wdata,
   output logic      [DATA_WIDTH-1:0]    rdata
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule
`default_nettype wire

FILE: sv/rgb565_framebuffer_blend_engine.sv
// Top level of the RGB565 frame store with pixel write, blend, fill, read and changed flag.
// Path from accepted transfer to result strobe: pixel write, opaque blend, clipped pixel,
// flag take and unused command finish in the execute state; read adds a frame store read;
// other blends read, multiply and write back; a rectangle fill writes each covered pixel
// in turn, bounded by the single frame store port. A new command can be taken while the
// result strobe is high. Reset clears the control state and changed flag and loads width
// 128 and height 160; the frame store itself is not cleared.
`default_nettype none
module rgb565_framebuffer_blend_engine #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic [2:0]                             req_cmd,
   input  wire logic [15:0]                            req_pixel_colour,
   input  wire logic [7:0]                             req_alpha_level,
   input  wire logic signed [9:0]                      req_x_pos,
   input  wire logic signed [9:0]                      req_y_pos,
   input  wire logic [9:0]                             req_span_x,
   input  wire logic [9:0]                             req_span_y,
   output logic                                        rsp_strobe,
   output logic [15:0]                                 rsp_stored_word,
   output logic                                        rsp_dirty_flag,
   output logic                                        rsp_was_clipped,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [rgbfb_pkg::CsrAddrWidth-1:0]     paddr,
   input  wire logic [rgbfb_pkg::CsrDataWidth-1:0]     pwdata,
   output logic      [rgbfb_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                        pready
);

   localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrWidth = $clog2(Depth);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_WRITE_BACK,
      S_FILL
   } state_type;

   state_type state_ff;

   logic [8:0] width_ff;
   logic [8:0] height_ff;
   logic [8:0] eff_w;
   logic [8:0] eff_h;

   logic [2:0]  cmd_ff;
   logic [15:0] colour_ff;
   logic [7:0]  alpha_ff;
   logic [9:0]  x_ff;
   logic [9:0]  y_ff;
   logic [9:0]  span_x_ff;
   logic [9:0]  span_y_ff;
   logic        before_ff;
   logic        changed_ff;
   logic [AddrWidth-1:0] row_base_ff;

   logic [8:0] col_ff;
   logic [8:0] row_ff;
   logic [8:0] x0_ff;
   logic [8:0] x_end_ff;
   logic [8:0] y_end_ff;

   logic [31:0] mul_ff;
   logic [31:0] bg_ff;

   logic        rsp_strobe_ff;
   logic [15:0] rsp_word_ff;
   logic        rsp_dirty_ff;
   logic        rsp_clipped_ff;

   logic        csr_write;
   logic        accept;
   logic [8:0]  y_clamp;
   logic [17:0] row_product;
   logic        on_screen;
   logic [AddrWidth-1:0] pix_addr;
   logic [AddrWidth-1:0] fill_addr;
   logic [8:0]  x0;
   logic [8:0]  y0;
   logic signed [11:0] x_sum;
   logic signed [11:0] y_sum;
   logic signed [11:0] x_lim;
   logic signed [11:0] y_lim;
   logic        rect_nonempty;
   logic        direct_write;
   logic        last_col;
   logic        last_row;

   logic [31:0] fg_spread;
   logic [31:0] bg_spread;
   logic [5:0]  scale;
   logic [31:0] blend_sum;
   logic [15:0] blend_word;

   logic                 mem_we;
   logic [AddrWidth-1:0] mem_addr;
   logic [15:0]          mem_wdata;
   logic [15:0]          mem_rdata;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == rgbfb_pkg::RegActiveHeight) ? {23'b0, height_ff}
                                                            : {23'b0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rgbfb_pkg::ResetActiveWidth;
         height_ff <= rgbfb_pkg::ResetActiveHeight;
      end else if (csr_write) begin
         if (paddr[2] == rgbfb_pkg::RegActiveWidth) begin
            width_ff <= pwdata[8:0];
         end else begin
            height_ff <= pwdata[8:0];
         end
      end
   end

   assign eff_w = ({2'b00, width_ff} > 11'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_ff;
   assign eff_h = ({2'b00, height_ff} > 11'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_ff;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign y_clamp = req_y_pos[9] ? 9'd0 : req_y_pos[8:0];
   assign row_product = y_clamp * eff_w;

   assign on_screen = !x_ff[9] && !y_ff[9] && (x_ff[8:0] < eff_w) && (y_ff[8:0] < eff_h);
   assign pix_addr = row_base_ff + AddrWidth'(x_ff[8:0]);
   assign fill_addr = row_base_ff + AddrWidth'(col_ff);

   assign x0 = x_ff[9] ? 9'd0 : x_ff[8:0];
   assign y0 = y_ff[9] ? 9'd0 : y_ff[8:0];
   assign x_sum = $signed({{2{x_ff[9]}}, x_ff}) + $signed({2'b00, span_x_ff});
   assign y_sum = $signed({{2{y_ff[9]}}, y_ff}) + $signed({2'b00, span_y_ff});
   assign x_lim = (x_sum > $signed({3'b000, eff_w})) ? $signed({3'b000, eff_w}) : x_sum;
   assign y_lim = (y_sum > $signed({3'b000, eff_h})) ? $signed({3'b000, eff_h}) : y_sum;
   assign rect_nonempty = (x_lim > $signed({3'b000, x0})) && (y_lim > $signed({3'b000, y0}));

   assign direct_write = on_screen && ((cmd_ff == rgbfb_pkg::CMD_PIXEL)
                         || ((cmd_ff == rgbfb_pkg::CMD_BLEND) && (alpha_ff == rgbfb_pkg::Opaque)));

   assign last_col = ({1'b0, col_ff} + 10'd1) == {1'b0, x_end_ff};
   assign last_row = ({1'b0, row_ff} + 10'd1) == {1'b0, y_end_ff};

   assign fg_spread = rgbfb_pkg::spread(colour_ff);
   assign bg_spread = rgbfb_pkg::spread(rgbfb_pkg::swap16(mem_rdata));
   assign scale = 6'(({1'b0, alpha_ff} + 9'd4) >> 3);
   assign blend_sum = bg_ff + ((mul_ff >> 5) & rgbfb_pkg::SpreadMask);
   assign blend_word = rgbfb_pkg::swap16(16'(blend_sum | (blend_sum >> 16)));

   always_comb begin
      mem_we = 1'b0;
      mem_addr = pix_addr;
      mem_wdata = rgbfb_pkg::swap16(colour_ff);
      unique case (state_ff)
         S_EXEC: begin
            mem_we = direct_write;
         end
         S_WRITE_BACK: begin
            mem_we = 1'b1;
            mem_wdata = blend_word;
         end
         S_FILL: begin
            mem_we = 1'b1;
            mem_addr = fill_addr;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   rgbfb_ram #(
      .DATA_WIDTH(16),
      .DEPTH(Depth)
   ) u_frame_store (
      .clock(clock),
      .we(mem_we),
      .addr(mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         changed_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff <= req_cmd;
                  colour_ff <= req_pixel_colour;
                  alpha_ff <= req_alpha_level;
                  x_ff <= req_x_pos;
                  y_ff <= req_y_pos;
                  span_x_ff <= req_span_x;
                  span_y_ff <= req_span_y;
                  before_ff <= changed_ff;
                  row_base_ff <= AddrWidth'(row_product);
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_word_ff <= 16'h0000;
               rsp_dirty_ff <= before_ff;
               rsp_clipped_ff <= 1'b0;
               priority if ((cmd_ff == rgbfb_pkg::CMD_PIXEL) || (cmd_ff == rgbfb_pkg::CMD_BLEND)
                            || (cmd_ff == rgbfb_pkg::CMD_READ)) begin
                  priority if (!on_screen) begin
                     rsp_clipped_ff <= 1'b1;
                     rsp_strobe_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else if (direct_write) begin
                     changed_ff <= 1'b1;
                     rsp_strobe_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_READ;
                  end
               end else if (cmd_ff == rgbfb_pkg::CMD_RECT) begin
                  changed_ff <= 1'b1;
                  col_ff <= x0;
                  row_ff <= y0;
                  x0_ff <= x0;
                  x_end_ff <= x_lim[8:0];
                  y_end_ff <= y_lim[8:0];
                  if (rect_nonempty) begin
                     state_ff <= S_FILL;
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else if (cmd_ff == rgbfb_pkg::CMD_TAKE) begin
                  changed_ff <= 1'b0;
                  rsp_strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_READ: begin
               if (cmd_ff == rgbfb_pkg::CMD_READ) begin
                  rsp_word_ff <= mem_rdata;
                  rsp_strobe_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  mul_ff <= 32'((fg_spread - bg_spread) * {26'b0, scale});
                  bg_ff <= bg_spread;
                  state_ff <= S_WRITE_BACK;
               end
            end
            S_WRITE_BACK: begin
               changed_ff <= 1'b1;
               rsp_strobe_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_FILL: begin
               if (last_col) begin
                  if (last_row) begin
                     rsp_strobe_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     row_ff <= row_ff + 9'd1;
                     col_ff <= x0_ff;
                     row_base_ff <= row_base_ff + AddrWidth'(eff_w);
                  end
               end else begin
                  col_ff <= col_ff + 9'd1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_stored_word = rsp_word_ff;
   assign rsp_dirty_flag = rsp_dirty_ff;
   assign rsp_was_clipped = rsp_clipped_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Accepted transfer did not make the engine busy.");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe stayed high for two cycles.");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == S_IDLE))
      else $error("Result issued while a command is still in progress.");

   a_clipped_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_was_clipped) |-> (rsp_stored_word == 16'h0000))
      else $error("Clipped command returned a nonzero stored word.");

endmodule
`default_nettype wire

FILE: dv/tb_rgb565_framebuffer_blend_engine.sv
// Self-checking testbench for the RGB565 frame store blend engine with a predicting scoreboard.
module tb_rgb565_framebuffer_blend_engine;

   localparam int MaxWidth = 256;
   localparam int MaxHeight = 256;
   localparam int FrameWords = MaxWidth * MaxHeight;
   localparam int CycleLimit = 4_000_000;
   localparam int BigFillCap = 8;
   localparam int NumPhases = 10;

   localparam int CsrAddrWidth = rgbfb_pkg::CsrAddrWidth;
   localparam int CsrDataWidth = rgbfb_pkg::CsrDataWidth;
   localparam int RegWidth = rgbfb_pkg::RegWidth;

   localparam logic [2:0] CmdSpareA = 3'd5;
   localparam logic [2:0] CmdSpareB = 3'd6;
   localparam logic [2:0] CmdSpareC = 3'd7;

   localparam logic [CsrAddrWidth-1:0] AddrActiveWidth =
      CsrAddrWidth'(4 * int'(rgbfb_pkg::RegActiveWidth));
   localparam logic [CsrAddrWidth-1:0] AddrActiveHeight =
      CsrAddrWidth'(4 * int'(rgbfb_pkg::RegActiveHeight));

   typedef struct packed {
      logic [2:0]        cmd;
      logic [15:0]       colour;
      logic [7:0]        alpha;
      logic signed [9:0] x_pos;
      logic signed [9:0] y_pos;
      logic [9:0]        span_x;
      logic [9:0]        span_y;
   } cmd_item_type;

   typedef struct packed {
      logic [15:0] word;
      logic        dirty;
      logic        clipped;
   } reply_type;

   class frame_scoreboard_type;
      logic [15:0] frame [FrameWords];
      bit written [FrameWords];
      bit changed;
      logic [RegWidth-1:0] width_reg;
      logic [RegWidth-1:0] height_reg;
      reply_type pending_replies[$];
      int errors;

      function new();
         changed = 1'b0;
         width_reg = rgbfb_pkg::ResetActiveWidth;
         height_reg = rgbfb_pkg::ResetActiveHeight;
         errors = 0;
      endfunction

      function int vis_w();
         return (int'(width_reg) > MaxWidth) ? MaxWidth : int'(width_reg);
      endfunction

      function int vis_h();
         return (int'(height_reg) > MaxHeight) ? MaxHeight : int'(height_reg);
      endfunction

      function bit on_panel(int x, int y);
         return x >= 0 && y >= 0 && x < vis_w() && y < vis_h();
      endfunction

      function int unsigned word_index(int x, int y);
         return (y * vis_w() + x) % FrameWords;
      endfunction

      function bit safe_access(int x, int y);
         return !on_panel(x, y) || written[word_index(x, y)];
      endfunction

      function void set_register(logic index, logic [RegWidth-1:0] value);
         if (index == rgbfb_pkg::RegActiveWidth) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
      endfunction

      function logic [15:0] mixed(logic [15:0] colour, logic [15:0] stored, logic [7:0] alpha);
         logic [31:0] fg;
         logic [31:0] bg;
         logic [31:0] scale;
         logic [15:0] back;
         logic [15:0] merged;
         back = {stored[7:0], stored[15:8]};
         scale = (32'(alpha) + 32'd4) >> 3;
         fg = ({16'h0000, colour} | {colour, 16'h0000}) & rgbfb_pkg::SpreadMask;
         bg = ({16'h0000, back} | {back, 16'h0000}) & rgbfb_pkg::SpreadMask;
         bg = bg + ((((fg - bg) * scale) >> 5) & rgbfb_pkg::SpreadMask);
         merged = bg[15:0] | bg[31:16];
         return {merged[7:0], merged[15:8]};
      endfunction

      function void note_command(cmd_item_type c);
         reply_type want;
         int x;
         int y;
         int x0;
         int y0;
         int x1;
         int y1;
         int unsigned a;
         logic [15:0] stored_form;
         want = '0;
         want.dirty = changed;
         x = $signed(c.x_pos);
         y = $signed(c.y_pos);
         stored_form = {c.colour[7:0], c.colour[15:8]};
         case (c.cmd)
            rgbfb_pkg::CMD_PIXEL, rgbfb_pkg::CMD_BLEND, rgbfb_pkg::CMD_READ: begin
               if (!on_panel(x, y)) begin
                  want.clipped = 1'b1;
               end else begin
                  a = word_index(x, y);
                  if (c.cmd == rgbfb_pkg::CMD_READ) begin
                     want.word = frame[a];
                  end else begin
                     if (c.cmd == rgbfb_pkg::CMD_PIXEL || c.alpha == rgbfb_pkg::Opaque) begin
                        frame[a] = stored_form;
                     end else begin
                        frame[a] = mixed(c.colour, frame[a], c.alpha);
                     end
                     written[a] = 1'b1;
                     changed = 1'b1;
                  end
               end
            end
            rgbfb_pkg::CMD_RECT: begin
               x0 = (x < 0) ? 0 : x;
               y0 = (y < 0) ? 0 : y;
               x1 = x + int'(c.span_x);
               y1 = y + int'(c.span_y);
               if (x1 > vis_w()) x1 = vis_w();
               if (y1 > vis_h()) y1 = vis_h();
               for (int j = y0; j < y1; j++) begin
                  for (int i = x0; i < x1; i++) begin
                     frame[word_index(i, j)] = stored_form;
                     written[word_index(i, j)] = 1'b1;
                  end
               end
               changed = 1'b1;
            end
            rgbfb_pkg::CMD_TAKE: begin
               changed = 1'b0;
            end
            default: begin
            end
         endcase
         pending_replies.push_back(want);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $error("unexpected result: stored_word %h dirty_flag %b was_clipped %b",
                   got.word, got.dirty, got.clipped);
            errors += 1;
            return;
         end
         want = pending_replies.pop_front();
         if (got.word !== want.word) begin
            $error("stored_word mismatch: expected %h, actual %h", want.word, got.word);
            errors += 1;
         end
         if (got.dirty !== want.dirty) begin
            $error("dirty_flag mismatch: expected %b, actual %b", want.dirty, got.dirty);
            errors += 1;
         end
         if (got.clipped !== want.clipped) begin
            $error("was_clipped mismatch: expected %b, actual %b", want.clipped, got.clipped);
            errors += 1;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_cmd = '0;
   logic [15:0] req_pixel_colour = '0;
   logic [7:0] req_alpha_level = '0;
   logic signed [9:0] req_x_pos = '0;
   logic signed [9:0] req_y_pos = '0;
   logic [9:0] req_span_x = '0;
   logic [9:0] req_span_y = '0;
   logic rsp_strobe;
   logic [15:0] rsp_stored_word;
   logic rsp_dirty_flag;
   logic rsp_was_clipped;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic pready;

   frame_scoreboard_type board;
   int cycle_count = 0;
   int big_fills = 0;

   rgb565_framebuffer_blend_engine #(
      .MAX_WIDTH(MaxWidth),
      .MAX_HEIGHT(MaxHeight)
   ) u_top (
      .clock,
      .reset,
      .start,
      .busy,
      .req_cmd,
      .req_pixel_colour,
      .req_alpha_level,
      .req_x_pos,
      .req_y_pos,
      .req_span_x,
      .req_span_y,
      .rsp_strobe,
      .rsp_stored_word,
      .rsp_dirty_flag,
      .rsp_was_clipped,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         board.check_reply({rsp_stored_word, rsp_dirty_flag, rsp_was_clipped});
      end
   end

   function automatic cmd_item_type make_command(logic [2:0] cmd, logic [15:0] colour,
                                                 logic [7:0] alpha, int x, int y,
                                                 int sx, int sy);
      cmd_item_type c;
      c.cmd = cmd;
      c.colour = colour;
      c.alpha = alpha;
      c.x_pos = 10'(x);
      c.y_pos = 10'(y);
      c.span_x = 10'(sx);
      c.span_y = 10'(sy);
      return c;
   endfunction

   function automatic logic signed [9:0] pick_coord(int limit);
      int r;
      r = $urandom_range(0, 9);
      if (limit > 0 && r < 6) return 10'($urandom_range(0, limit - 1));
      if (limit > 0 && r == 6) return 10'(limit - 1);
      if (r == 7) return 10'(limit);
      if (r == 8) return 10'h3FF;
      return 10'($urandom());
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic cmd_item_type random_command();
      cmd_item_type c;
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) c.cmd = rgbfb_pkg::CMD_PIXEL;
      else if (r < 50) c.cmd = rgbfb_pkg::CMD_BLEND;
      else if (r < 65) c.cmd = rgbfb_pkg::CMD_RECT;
      else if (r < 85) c.cmd = rgbfb_pkg::CMD_READ;
      else if (r < 94) c.cmd = rgbfb_pkg::CMD_TAKE;
      else c.cmd = 3'($urandom_range(CmdSpareA, CmdSpareC));
      c.colour = 16'($urandom());
      r = $urandom_range(0, 9);
      c.alpha = (r == 0) ? rgbfb_pkg::Opaque : (r == 1) ? 8'd0 : 8'($urandom());
      c.x_pos = pick_coord(board.vis_w());
      c.y_pos = pick_coord(board.vis_h());
      c.span_x = 10'($urandom_range(0, 512));
      c.span_y = 10'($urandom_range(0, 512));
      if (c.cmd == rgbfb_pkg::CMD_RECT) begin
         if (big_fills < BigFillCap && $urandom_range(0, 59) == 0) begin
            big_fills++;
         end else begin
            c.span_x = 10'($urandom_range(0, 8));
            c.span_y = 10'($urandom_range(0, 8));
         end
      end
      if ((c.cmd == rgbfb_pkg::CMD_READ || c.cmd == rgbfb_pkg::CMD_BLEND) &&
          !board.safe_access($signed(c.x_pos), $signed(c.y_pos))) begin
         c.cmd = rgbfb_pkg::CMD_PIXEL;
      end
      return c;
   endfunction

   task automatic send_command(cmd_item_type c);
      start <= 1'b1;
      req_cmd <= c.cmd;
      req_pixel_colour <= c.colour;
      req_alpha_level <= c.alpha;
      req_x_pos <= c.x_pos;
      req_y_pos <= c.y_pos;
      req_span_x <= c.span_x;
      req_span_y <= c.span_y;
      do @(posedge clock); while (busy);
      board.note_command(c);
   endtask

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic [CsrAddrWidth-1:0] a,
                             logic [CsrDataWidth-1:0] d, output logic [CsrDataWidth-1:0] rd);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= a;
      pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
   endtask

   task automatic check_register(string name, logic [CsrAddrWidth-1:0] a,
                                 logic [RegWidth-1:0] want);
      logic [CsrDataWidth-1:0] got;
      csr_access(1'b0, a, '0, got);
      if (got !== CsrDataWidth'(want)) begin
         $error("%s readback mismatch: expected %h, actual %h", name, CsrDataWidth'(want), got);
         board.errors += 1;
      end
   endtask

   task automatic configure(logic [RegWidth-1:0] w, logic [RegWidth-1:0] h);
      logic [CsrDataWidth-1:0] ignored;
      drain_results();
      csr_access(1'b1, AddrActiveWidth, {23'($urandom()), w}, ignored);
      board.set_register(rgbfb_pkg::RegActiveWidth, w);
      csr_access(1'b1, AddrActiveHeight, {23'($urandom()), h}, ignored);
      board.set_register(rgbfb_pkg::RegActiveHeight, h);
      check_register("active_width", AddrActiveWidth, w);
      check_register("active_height", AddrActiveHeight, h);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic run_directed();
      cmd_item_type list[$];
      list.push_back(make_command(rgbfb_pkg::CMD_PIXEL, 16'hFFFF, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_READ, 16'h0000, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_TAKE, 16'h0000, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_TAKE, 16'h0000, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_BLEND, 16'h0000, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_BLEND, 16'h001F, 8'd128, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_BLEND, 16'hF800, 8'd254, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_READ, 16'h0000, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_BLEND, 16'h1234, rgbfb_pkg::Opaque,
                                  0, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_PIXEL, 16'h0000, 8'd0, 127, 159, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_READ, 16'h0000, 8'd0, 127, 159, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_PIXEL, 16'hABCD, 8'd0, 128, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_BLEND, 16'hABCD, 8'd77, 0, 160, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_READ, 16'h0000, 8'd0, -1, 0, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_PIXEL, 16'h07E0, 8'd0, -512, 511, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_RECT, 16'h5555, 8'd0, -2, -3, 5, 6));
      list.push_back(make_command(rgbfb_pkg::CMD_READ, 16'h0000, 8'd0, 2, 2, 0, 0));
      list.push_back(make_command(rgbfb_pkg::CMD_RECT, 16'hAAAA, 8'd0, 128, 0, 10, 10));
      list.push_back(make_command(rgbfb_pkg::CMD_RECT, 16'h1111, 8'd0, 10, 10, 0, 7));
      list.push_back(make_command(rgbfb_pkg::CMD_TAKE, 16'h0000, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(CmdSpareA, 16'hFFFF, rgbfb_pkg::Opaque,
                                  511, -512, 512, 512));
      list.push_back(make_command(CmdSpareB, 16'h0000, 8'd0, 0, 0, 0, 0));
      list.push_back(make_command(CmdSpareC, 16'h8001, 8'd1, 3, 3, 1, 1));
      list.push_back(make_command(rgbfb_pkg::CMD_RECT, 16'hC3C3, 8'd0, 126, 158, 512, 512));
      list.push_back(make_command(rgbfb_pkg::CMD_READ, 16'h0000, 8'd0, 127, 159, 0, 0));
      foreach (list[i]) begin
         send_command(list[i]);
         idle_sender(pick_gap());
      end
   endtask

   initial begin
      int phase_w[NumPhases];
      int phase_h[NumPhases];
      int phase_items[NumPhases];
      bit no_idle;
      board = new();
      phase_w = '{256, 511, 1, 0, 0, 300, 128, 0, 0, 0};
      phase_h = '{256, 511, 1, 0, 200, 17, 160, 0, 0, 0};
      phase_items = '{300, 200, 150, 100, 100, 250, 250, 200, 200, 200};
      for (int p = 7; p < NumPhases; p++) begin
         phase_w[p] = $urandom_range(0, 511);
         phase_h[p] = $urandom_range(0, 511);
      end
      no_idle = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      check_register("active_width", AddrActiveWidth, rgbfb_pkg::ResetActiveWidth);
      check_register("active_height", AddrActiveHeight, rgbfb_pkg::ResetActiveHeight);
      psel <= 1'b0;
      penable <= 1'b0;
      run_directed();
      for (int p = 0; p < NumPhases; p++) begin
         configure(RegWidth'(phase_w[p]), RegWidth'(phase_h[p]));
         if (p == 0) begin
            send_command(make_command(rgbfb_pkg::CMD_RECT, 16'($urandom()), 8'd0,
                                      -1, -1, 512, 512));
         end
         for (int k = 0; k < phase_items[p]; k++) begin
            if (k % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (k == phase_items[p] / 2) drain_results();
            send_command(random_command());
            idle_sender(no_idle ? 0 : pick_gap());
         end
      end
      drain_results();
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
